@@ rtl/apbs_pkg.sv @@
// Shared constants and types for the approximate pattern bit search block.
`timescale 1ns / 1ps

package apbs_pkg;

   localparam int PATTERN_W = 64;
   localparam int ERR_W     = 7;
   localparam int TAG_W     = 16;
   localparam int POS_W     = 17;
   localparam int CSR_IDX_W = 2;

   // Register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ERR_LIMIT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROUND_TAG = 2'd2;

   localparam logic [ERR_W-1:0] ERR_LIMIT_RESET = 7'd6;

   typedef struct packed {
      logic signed [POS_W-1:0] pos;
      logic [ERR_W-1:0]        errs;
   } result_type;

endpackage

@@ rtl/approx_pattern_bit_search.sv @@
// Top level of the approximate pattern bit search: window, scoring and result queue.
`timescale 1ns / 1ps

// Sliding-window approximate match of a configured pattern against a bit stream.
// Request channel (req_*): one stream bit per word, req_last_bit marks the end of
// a stream. A word is taken when req_valid is high and req_stall is low.
// Response channel (rsp_*): one word per match, with its start position (which
// may be negative), its mismatch count, the round tag and run_end on the final
// match caused by one request word. Taken when rsp_valid is high, rsp_stall low.
// Configuration (csr_*): pattern, error limit and round tag, written by csr_wr_en.
// Order: a match of an ordinary bit passes the scoring stage, then the output
// register, after its request word is taken; during a tail sweep each match is
// held until the next match of the same word or the end of the sweep is known.
// Throughput: one request word per cycle for ordinary bits while rsp is not
// stalled. A last bit scores its own alignment plus up to min(error limit,
// WINDOW_BITS-1) tail alignments, one per cycle in the shared scoring stage
// while rsp is not stalled. If its final alignment matches after an earlier one
// of that word matched, the final match is sent before the next word is scored.
// Reset clears the window, the bit counter, all pending work and the registers
// (error limit to 6). A stall on rsp holds the output word; the scoring stage and
// then req_stall back up behind it, so no word is lost.
module approx_pattern_bit_search
   import apbs_pkg::*;
#(
   parameter int WINDOW_BITS     = 64,
   parameter int MAX_STREAM_BITS = 65536
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_stream_bit,
   input  logic                    req_last_bit,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [POS_W-1:0] rsp_match_position,
   output logic [ERR_W-1:0]        rsp_mismatch_count,
   output logic [TAG_W-1:0]        rsp_tag_out,
   output logic                    rsp_run_end,
   input  logic                    csr_wr_en,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [PATTERN_W-1:0]    csr_wdata
);

   localparam int W      = WINDOW_BITS;
   localparam int SEEN_W = $clog2(MAX_STREAM_BITS + 1);
   localparam int IW     = $clog2(W);
   localparam int REACH_W = SEEN_W + 1;
   localparam int PC_W   = $clog2(W + 1);
   localparam int PW     = ((SEEN_W > POS_W) ? SEEN_W : POS_W) + 1;

   // configuration registers
   logic [PATTERN_W-1:0] pattern_ff;
   logic [ERR_W-1:0]     max_err_ff;
   logic [TAG_W-1:0]     tag_ff;

   // stream state
   logic [W-1:0]      window_ff, window_in;
   logic [SEEN_W-1:0] seen_ff, seen_in;

   // scoring stage: snapshot of one request word and its alignment sweep
   logic              job_valid_ff, job_valid_in;
   logic [W-1:0]      job_window_ff, job_window_in;
   logic [SEEN_W-1:0] job_seen_ff, job_seen_in;
   logic [IW-1:0]     job_shift_ff, job_shift_in;
   logic [IW-1:0]     job_ntails_ff, job_ntails_in;

   // one held-back match, so run_end can be set once the sweep is known to be over
   logic       pend_valid_ff, pend_valid_in;
   logic       pend_final_ff, pend_final_in;
   result_type pend_ff, pend_in;

   // output register
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff, rsp_in;
   logic       rsp_end_ff, rsp_end_in;
   logic [TAG_W-1:0] rsp_tag_ff, rsp_tag_in;

   logic out_free, flush_go, eval_go, job_done, req_take;
   logic [W-1:0]       window_next;
   logic [SEEN_W-1:0]  seen_next;
   logic [IW-1:0]      ntails;
   logic [W-1:0]       ref_bits, shifted, hi_mask, lo_mask, diff;
   logic [REACH_W-1:0] reach;
   logic [IW-1:0]      hi;
   logic [PC_W-1:0]    pc;
   logic [ERR_W-1:0]   errs;
   logic [PW-1:0]      pos_wide;
   logic               is_match;
   result_type         cand;

   // ---------------- configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff <= '0;
         max_err_ff <= ERR_LIMIT_RESET;
         tag_ff     <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_PATTERN:   pattern_ff <= csr_wdata;
            CSR_ERR_LIMIT: max_err_ff <= csr_wdata[ERR_W-1:0];
            CSR_ROUND_TAG: tag_ff     <= csr_wdata[TAG_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- handshake control
   // Output register can take a word when empty or being drained this cycle.
   assign out_free = !rsp_valid_ff || !rsp_stall;
   // A held match that closes a finished sweep goes out before anything else.
   assign flush_go = pend_valid_ff && pend_final_ff && out_free;
   assign eval_go  = job_valid_ff && out_free && !(pend_valid_ff && pend_final_ff);
   assign job_done = (job_shift_ff == job_ntails_ff);
   assign req_stall = job_valid_ff && !(eval_go && job_done);
   assign req_take  = req_valid && !req_stall;

   // ---------------- window advance on an accepted word
   always_comb begin
      window_next = {window_ff[W-2:0], req_stream_bit};
      seen_next   = (seen_ff < SEEN_W'(MAX_STREAM_BITS)) ? seen_ff + 1'b1 : seen_ff;
      // tail sweep length: threshold, capped so every alignment overlaps the stream
      if (!req_last_bit) begin
         ntails = '0;
      end else if (max_err_ff >= ERR_W'(W - 1)) begin
         ntails = IW'(W - 1);
      end else begin
         ntails = max_err_ff[IW-1:0];
      end
   end

   // ---------------- score one alignment
   always_comb begin
      ref_bits = pattern_ff[PATTERN_W-1 -: W];
      shifted  = job_window_ff << job_shift_ff;
      // highest pattern bit that still meets a stream bit
      reach = REACH_W'(job_seen_ff) - REACH_W'(1) + REACH_W'(job_shift_ff);
      if (reach >= REACH_W'(W - 1)) begin
         hi = IW'(W - 1);
      end else begin
         hi = reach[IW-1:0];
      end
      hi_mask = {W{1'b1}} >> (IW'(W - 1) - hi);
      lo_mask = {W{1'b1}} << job_shift_ff;
      diff    = (ref_bits ^ shifted) & hi_mask & lo_mask;
      pc = '0;
      for (int b = 0; b < W; b++) begin
         pc = pc + PC_W'(diff[b]);
      end
      // overhang: bits above hi plus the shift below
      errs = ERR_W'(pc) + ERR_W'(IW'(W - 1) - hi) + ERR_W'(job_shift_ff);
      is_match = (errs <= max_err_ff);
      pos_wide = PW'(job_seen_ff) + PW'(job_shift_ff) - PW'(W);
      cand.pos  = pos_wide[POS_W-1:0];
      cand.errs = errs;
   end

   // ---------------- next state
   always_comb begin
      window_in     = window_ff;
      seen_in       = seen_ff;
      job_valid_in  = job_valid_ff;
      job_window_in = job_window_ff;
      job_seen_in   = job_seen_ff;
      job_shift_in  = job_shift_ff;
      job_ntails_in = job_ntails_ff;
      pend_valid_in = pend_valid_ff;
      pend_final_in = pend_final_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_in        = rsp_ff;
      rsp_end_in    = rsp_end_ff;
      rsp_tag_in    = rsp_tag_ff;

      if (flush_go) begin
         rsp_valid_in  = 1'b1;
         rsp_in        = pend_ff;
         rsp_end_in    = 1'b1;
         rsp_tag_in    = tag_ff;
         pend_valid_in = 1'b0;
         pend_final_in = 1'b0;
      end else if (eval_go) begin
         if (is_match) begin
            if (pend_valid_ff) begin
               // older match is not the last: send it, hold the new one
               rsp_valid_in  = 1'b1;
               rsp_in        = pend_ff;
               rsp_end_in    = 1'b0;
               rsp_tag_in    = tag_ff;
               pend_in       = cand;
               pend_valid_in = 1'b1;
               pend_final_in = job_done;
            end else if (job_done) begin
               rsp_valid_in = 1'b1;
               rsp_in       = cand;
               rsp_end_in   = 1'b1;
               rsp_tag_in   = tag_ff;
            end else begin
               pend_in       = cand;
               pend_valid_in = 1'b1;
               pend_final_in = 1'b0;
            end
         end else if (job_done && pend_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_in        = pend_ff;
            rsp_end_in    = 1'b1;
            rsp_tag_in    = tag_ff;
            pend_valid_in = 1'b0;
         end

         if (job_done) begin
            job_valid_in = 1'b0;
         end else begin
            job_shift_in = job_shift_ff + 1'b1;
         end
      end

      if (req_take) begin
         job_valid_in  = 1'b1;
         job_window_in = window_next;
         job_seen_in   = seen_next;
         job_shift_in  = '0;
         job_ntails_in = ntails;
         // a last bit closes the stream: drop the window and restart the count
         window_in = req_last_bit ? '0 : window_next;
         seen_in   = req_last_bit ? '0 : seen_next;
      end
   end

   // ---------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff     <= '0;
         seen_ff       <= '0;
         job_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
         pend_final_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         window_ff     <= window_in;
         seen_ff       <= seen_in;
         job_valid_ff  <= job_valid_in;
         pend_valid_ff <= pend_valid_in;
         pend_final_ff <= pend_final_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_window_ff <= job_window_in;
      job_seen_ff   <= job_seen_in;
      job_shift_ff  <= job_shift_in;
      job_ntails_ff <= job_ntails_in;
      pend_ff       <= pend_in;
      rsp_ff        <= rsp_in;
      rsp_end_ff    <= rsp_end_in;
      rsp_tag_ff    <= rsp_tag_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_match_position = rsp_ff.pos;
   assign rsp_mismatch_count = rsp_ff.errs;
   assign rsp_tag_out        = rsp_tag_ff;
   assign rsp_run_end        = rsp_end_ff;

endmodule

@@ test/approx_pattern_bit_search_test.sv @@
// Self-checking testbench for the approximate pattern bit search block.
`timescale 1ns / 1ps

module approx_pattern_bit_search_test;
   import apbs_pkg::*;

   localparam int WINDOW          = 64;
   localparam int MAX_STREAM_BITS = 65536;
   localparam int SETTLE_CYCLES   = 80;      // covers the scoring and output registers plus the longest tail pass
   localparam int HOLD_CYCLES     = 300;     // long receiver hold-off for the pressure test
   localparam int IDLE_PCT        = 20;      // chance of an idle burst before a word

   // One expected match word, field for field as it leaves the block
   typedef struct packed {
      logic signed [POS_W-1:0] position;
      logic [ERR_W-1:0]        errors;
      logic [TAG_W-1:0]        tag;
      logic                    run_end;
   } match_word_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic                    req_stream_bit = 1'b0;
   logic                    req_last_bit = 1'b0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic signed [POS_W-1:0] rsp_match_position;
   logic [ERR_W-1:0]        rsp_mismatch_count;
   logic [TAG_W-1:0]        rsp_tag_out;
   logic                    rsp_run_end;
   logic                    csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index = CSR_PATTERN;
   logic [PATTERN_W-1:0]    csr_wdata = '0;

   // Predictor copy of the registers (reset values) and of the stream state
   logic [PATTERN_W-1:0] cfg_pattern   = '0;
   logic [ERR_W-1:0]     cfg_err_limit = ERR_LIMIT_RESET;
   logic [TAG_W-1:0]     cfg_tag       = '0;
   logic [WINDOW-1:0]    stream_window = '0;
   int                   stream_count  = 0;

   match_word_type predicted_matches[$];
   int             bits_sent    = 0;
   int             mismatches   = 0;
   logic           idle_on      = 1'b1;
   logic           hold_request = 1'b0;

   approx_pattern_bit_search uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_stream_bit     (req_stream_bit),
      .req_last_bit       (req_last_bit),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_match_position (rsp_match_position),
      .rsp_mismatch_count (rsp_mismatch_count),
      .rsp_tag_out        (rsp_tag_out),
      .rsp_run_end        (rsp_run_end),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Score every alignment this bit closes: the one ending at the newest bit and,
   // on a last bit, the tail shifts that hang past the stream end. Overhanging
   // pattern bits at either end count as one error each.
   function automatic void score_stream_bit(input logic bit_val, input logic last_val);
      logic [WINDOW-1:0] valid_mask;
      match_word_type    found;
      logic              have_found;
      int                top;
      int                tail_count;
      int                errors;
      int                i;
      stream_window = {stream_window[WINDOW-2:0], bit_val};
      if (stream_count < MAX_STREAM_BITS) stream_count++;   // positions freeze once saturated
      tail_count = 0;
      if (last_val) tail_count = (int'(cfg_err_limit) > WINDOW - 1) ? WINDOW - 1
                                                                    : int'(cfg_err_limit);
      have_found = 1'b0;
      found = '0;
      for (i = 0; i <= tail_count; i++) begin
         top = stream_count - 1 + i;
         if (top > WINDOW - 1) top = WINDOW - 1;
         valid_mask = ({WINDOW{1'b1}} >> (WINDOW - 1 - top)) & ({WINDOW{1'b1}} << i);
         errors = $countones((cfg_pattern ^ (stream_window << i)) & valid_mask)
                + WINDOW - $countones(valid_mask);
         if (errors <= int'(cfg_err_limit)) begin
            // hold back the newest match so run_end can go on the final one
            if (have_found) begin
               predicted_matches.insert(predicted_matches.size(), found);
            end
            found.position = POS_W'(stream_count + i - WINDOW);
            found.errors   = ERR_W'(errors);
            found.tag      = cfg_tag;
            found.run_end  = 1'b0;
            have_found     = 1'b1;
         end
      end
      if (have_found) begin
         found.run_end = 1'b1;
         predicted_matches.insert(predicted_matches.size(), found);
      end
      if (last_val) begin
         stream_count  = 0;
         stream_window = '0;
      end
   endfunction

   // Offer one stream bit, maybe after an idle burst, and score it once taken
   task automatic send_bit(input logic bit_val, input logic last_val);
      int gap;
      if (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
         gap = $urandom_range(1, 9);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_stream_bit <= bit_val;
      req_last_bit   <= last_val;
      do @(posedge clock); while (req_stall);
      score_stream_bit(bit_val, last_val);
      bits_sent++;
   endtask

   // Drop valid, let every expected match drain, then let the tail pass finish
   task automatic settle();
      req_valid <= 1'b0;
      while (predicted_matches.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write all three registers back to back; only called while the block is idle
   task automatic configure(input logic [PATTERN_W-1:0] pattern_val,
                            input logic [ERR_W-1:0] limit_val,
                            input logic [TAG_W-1:0] tag_val);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_PATTERN;
      csr_wdata <= pattern_val;
      @(posedge clock);
      cfg_pattern = pattern_val;
      csr_index <= CSR_ERR_LIMIT;
      csr_wdata <= PATTERN_W'(limit_val);
      @(posedge clock);
      cfg_err_limit = limit_val;
      csr_index <= CSR_ROUND_TAG;
      csr_wdata <= PATTERN_W'(tag_val);
      @(posedge clock);
      cfg_tag = tag_val;
      csr_wr_en <= 1'b0;
   endtask

   // Random stream with the current pattern laid in at a random offset (it may
   // hang off either end) and a few bits flipped so near matches show up
   task automatic send_stream(input int length, input int flips, input logic close_it);
      logic [255:0] stream_buf;
      int           start;
      int           j;
      int           p;
      for (j = 0; j < length; j++) stream_buf[j] = 1'($urandom_range(0, 1));
      start = $urandom_range(0, length + 8) - 8;
      for (j = 0; j < WINDOW; j++) begin
         p = start + j;
         if (p >= 0 && p < length) stream_buf[p] = cfg_pattern[WINDOW - 1 - j];
      end
      repeat (flips) begin
         p = $urandom_range(0, length - 1);
         stream_buf[p] = ~stream_buf[p];
      end
      for (j = 0; j < length; j++) send_bit(stream_buf[j], close_it && j == length - 1);
   endtask

   // Registers straight out of reset: zero pattern, threshold six, tag zero
   task automatic test_reset_values();
      send_stream($urandom_range(12, 20), $urandom_range(0, 3), 1'b1);
      settle();
   endtask

   // Threshold at and just below the window size, one-bit streams, a short stream
   task automatic test_edge_cases();
      logic [19:0] short_bits;
      int          j;
      // one-bit stream: every tail shift overlaps a single bit, 64 matches
      configure(64'hAAAA_AAAA_AAAA_AAAA, 7'd64, 16'hFFFF);
      send_bit(1'b1, 1'b1);
      settle();
      configure({PATTERN_W{1'b1}}, 7'd64, 16'h0000);
      send_bit(1'b0, 1'b1);
      settle();
      // short stream, overhang at both ends
      configure(64'h8000_0000_0000_0001, 7'd63, 16'h8001);
      short_bits = 20'b1011_0011_1000_1111_0101;
      for (j = 19; j >= 0; j--) send_bit(short_bits[j], j == 0);
      settle();
   endtask

   // Random streams under random settings until enough words went by
   task automatic test_random_streams(input int item_goal);
      int               start_items;
      int               length;
      logic [ERR_W-1:0] limit;
      logic [PATTERN_W-1:0] pattern_val;
      start_items = bits_sent;
      while (bits_sent - start_items < item_goal) begin
         case ($urandom_range(0, 5))
            0:       limit = 7'd0;
            1:       limit = 7'($urandom_range(1, 3));
            2:       limit = 7'd64;
            3:       limit = 7'd63;
            default: limit = 7'($urandom_range(0, 12));
         endcase
         case ($urandom_range(0, 5))
            0:       pattern_val = '0;
            1:       pattern_val = '1;
            default: pattern_val = {$urandom, $urandom};
         endcase
         configure(pattern_val, limit, 16'($urandom_range(0, 65535)));
         length = ($urandom_range(0, 3) != 0) ? $urandom_range(64, 72)
                                              : $urandom_range(1, 63);
         // leave some streams open so they run on into the next setting
         send_stream(length, $urandom_range(0, (limit < 8) ? int'(limit) + 1 : 8),
                     $urandom_range(0, 99) < 85);
         settle();
      end
   endtask

   // Hold the receiver off while matches pile up, so the block backs up its input
   task automatic test_backpressure();
      configure({$urandom, $urandom}, 7'd64, 16'($urandom_range(0, 65535)));
      hold_request = 1'b1;
      send_stream(16, 0, 1'b1);
      settle();
   endtask

   // Receiver side: random stall bursts, plus one long hold-off when requested
   initial begin : rsp_stall_gen
      int n;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (!reset && idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
            n = $urandom_range(1, 9);
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Compare each accepted match word against the oldest prediction
   always @(posedge clock) begin : check_matches
      match_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (predicted_matches.size() == 0) begin
            $display("%0t: unexpected word, expected none, actual pos %0d errs %0d tag %0h end %0b",
                     $time, rsp_match_position, rsp_mismatch_count, rsp_tag_out, rsp_run_end);
            mismatches++;
         end else begin
            want = predicted_matches.pop_front();
            if (rsp_match_position !== want.position) begin
               $display("%0t: match_position expected %0d, actual %0d",
                        $time, want.position, rsp_match_position);
               mismatches++;
            end
            if (rsp_mismatch_count !== want.errors) begin
               $display("%0t: mismatch_count expected %0d, actual %0d",
                        $time, want.errors, rsp_mismatch_count);
               mismatches++;
            end
            if (rsp_tag_out !== want.tag) begin
               $display("%0t: tag_out expected %0h, actual %0h", $time, want.tag, rsp_tag_out);
               mismatches++;
            end
            if (rsp_run_end !== want.run_end) begin
               $display("%0t: run_end expected %0b, actual %0b",
                        $time, want.run_end, rsp_run_end);
               mismatches++;
            end
         end
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_values();
      test_edge_cases();
      test_random_streams(40);
      test_backpressure();
      // last stretch runs with no idling on either side
      idle_on = 1'b0;
      test_random_streams(30);
      settle();
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Watchdog: several times the slowest correct run
   initial begin
      #2_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
